@@ hdl/ogdsc_pkg.sv @@
// Shared types, constants and widths of the occupancy grid disc safety check.
// Used by the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ogdsc_pkg;

	localparam int DEF_MAX_COLS = 256;
	localparam int DEF_MAX_ROWS = 256;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int POS_W      = 24;
	localparam int RAD_W      = 16;
	localparam int GSZ_W      = 9;
	localparam int IDX_W      = 8;
	localparam int CELL_W     = 8;
	localparam int LIM_W      = 14;
	localparam int EDGE_W     = 28;
	localparam int MUL_W      = 32;
	localparam int PROD_W     = 64;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 8;

	localparam logic signed [CELL_W-1:0] CELL_FREE = 8'sd0;
	localparam logic signed [CELL_W-1:0] CELL_OCC  = 8'sd100;
	localparam logic signed [CELL_W-1:0] CELL_UNK  = -8'sd1;

	localparam logic [RAD_W-1:0] RST_RESOLUTION = 16'd256;
	localparam logic [RAD_W-1:0] RST_INV_RES    = 16'd256;
	localparam logic [RAD_W-1:0] RST_CHECK_RAD  = 16'd128;
	localparam logic [GSZ_W-1:0] RST_GRID_SIZE  = 9'd256;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_DISC  = 2'd2,
		REQ_QUERY = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OOB = 2'd1,
		ST_OCC = 2'd2,
		ST_UNK = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X = 3'd0,
		CFG_ORIGIN_Y = 3'd1,
		CFG_RES      = 3'd2,
		CFG_INV_RES  = 3'd3,
		CFG_CHECK_R  = 3'd4,
		CFG_GRID_W   = 3'd5,
		CFG_GRID_H   = 3'd6
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_WR, S_CLR,
		S_EX0, S_EX1, S_EY0, S_EY1, S_RR, S_CHK,
		S_XB, S_YB, S_DY, S_ROW, S_ROW2, S_CA, S_CB, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		MS_NONE, MS_X0, MS_X1, MS_Y0, MS_Y1, MS_RR, MS_XB, MS_YB, MS_DY, MS_DX
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     sweep_en;
		mul_sel_t mul_sel;
		logic     cap_x0;
		logic     cap_x1;
		logic     cap_y0;
		logic     cap_y1;
		logic     cap_rr;
		logic     clip;
		logic     set_dxb;
		logic     set_dy;
		logic     row_start;
		logic     cap_dy2;
		logic     rd_en;
		logic     wr_cell;
		logic     wr_free;
		logic     step_x;
		logic     step_y;
		logic     res_set;
		status_t  res_status;
		logic     res_safe;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		req_t req_in;
		req_t req_q;
		logic sweep_last;
		logic oob;
		logic empty;
		logic in_circle;
		logic cell_occ;
		logic cell_unk;
		logic x_end;
		logic y_end;
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

@@ hdl/ogdsc_ctrl.sv @@
// Controller state machine of the occupancy grid disc safety check.
// Depends on ogdsc_pkg; drives the datapath through cmd_t, watches sts_t.
`timescale 1ns / 1ps
`default_nettype none

module ogdsc_ctrl import ogdsc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output state_t    state
);

	state_t state_q, state_d;

	assign state = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (sts.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					unique case (sts.req_in)
						REQ_WRITE: state_d = S_WR;
						REQ_CLEAR: state_d = S_CLR;
						default:   state_d = S_EX0;
					endcase
				end
			end
			S_WR:   state_d = S_DONE;
			S_CLR: begin
				if (sts.sweep_last) state_d = S_DONE;
			end
			S_EX0:  state_d = S_EX1;
			S_EX1:  state_d = S_EY0;
			S_EY0:  state_d = S_EY1;
			S_EY1:  state_d = S_RR;
			S_RR:   state_d = S_CHK;
			S_CHK:  state_d = S_XB;
			S_XB: begin
				priority if (sts.req_q == REQ_QUERY && sts.oob) state_d = S_DONE;
				else if (sts.req_q == REQ_DISC && sts.empty) state_d = S_DONE;
				else state_d = S_YB;
			end
			S_YB:   state_d = S_DY;
			S_DY:   state_d = S_ROW;
			S_ROW:  state_d = S_ROW2;
			S_ROW2: state_d = S_CA;
			S_CA:   state_d = S_CB;
			S_CB: begin
				priority if (sts.req_q == REQ_QUERY && sts.in_circle &&
						(sts.cell_occ || sts.cell_unk)) state_d = S_DONE;
				else if (sts.x_end && sts.y_end) state_d = S_DONE;
				else if (sts.x_end) state_d = S_ROW;
				else state_d = S_CA;
			end
			S_DONE: begin
				if (!sts.out_busy) state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_sel = MS_NONE;
		cmd.res_status = ST_OK;
		unique case (state_q)
			S_INIT: cmd.sweep_en = 1'b1;
			S_IDLE: begin
				cmd.load = in_valid;
				cmd.res_set = in_valid;
			end
			S_WR:  cmd.wr_cell = 1'b1;
			S_CLR: cmd.sweep_en = 1'b1;
			S_EX0: cmd.mul_sel = MS_X0;
			S_EX1: begin
				cmd.cap_x0 = 1'b1;
				cmd.mul_sel = MS_X1;
			end
			S_EY0: begin
				cmd.cap_x1 = 1'b1;
				cmd.mul_sel = MS_Y0;
			end
			S_EY1: begin
				cmd.cap_y0 = 1'b1;
				cmd.mul_sel = MS_Y1;
			end
			S_RR: begin
				cmd.cap_y1 = 1'b1;
				cmd.mul_sel = MS_RR;
			end
			S_CHK: begin
				cmd.cap_rr = 1'b1;
				cmd.clip = 1'b1;
			end
			S_XB: begin
				cmd.mul_sel = MS_XB;
				if (sts.req_q == REQ_QUERY && sts.oob) begin
					cmd.res_set = 1'b1;
					cmd.res_status = ST_OOB;
				end
			end
			S_YB: begin
				cmd.set_dxb = 1'b1;
				cmd.mul_sel = MS_YB;
			end
			S_DY: cmd.set_dy = 1'b1;
			S_ROW: begin
				cmd.row_start = 1'b1;
				cmd.mul_sel = MS_DY;
			end
			S_ROW2: cmd.cap_dy2 = 1'b1;
			S_CA: begin
				cmd.rd_en = 1'b1;
				cmd.mul_sel = MS_DX;
			end
			S_CB: begin
				cmd.wr_free = (sts.req_q == REQ_DISC) && sts.in_circle;
				priority if (sts.req_q == REQ_QUERY && sts.in_circle && sts.cell_occ) begin
					cmd.res_set = 1'b1;
					cmd.res_status = ST_OCC;
				end else if (sts.req_q == REQ_QUERY && sts.in_circle && sts.cell_unk) begin
					cmd.res_set = 1'b1;
					cmd.res_status = ST_UNK;
				end else if (sts.x_end && sts.y_end) begin
					cmd.res_set = 1'b1;
					cmd.res_safe = (sts.req_q == REQ_QUERY);
				end else if (sts.x_end) begin
					cmd.step_y = 1'b1;
				end else begin
					cmd.step_x = 1'b1;
				end
			end
			S_DONE: cmd.out_load = !sts.out_busy;
			default: cmd.mul_sel = MS_NONE;
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/ogdsc_dp.sv @@
// Datapath of the occupancy grid disc safety check: configuration registers,
// grid memory, the shared multiplier, window edges and the cell walk.
// Depends on ogdsc_pkg; commanded by ogdsc_ctrl through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module ogdsc_dp import ogdsc_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	input  wire logic [1:0]            in_user,
	input  wire logic [IN_DATA_W-1:0]  in_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic [OUT_DATA_W-1:0]      out_data
);

	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int AW = CW + RW;
	localparam int DEPTH = 1 << AW;

	// Configuration registers.
	logic signed [POS_W-1:0] origin_x_q, origin_y_q;
	logic [RAD_W-1:0] res_q, inv_q, check_r_q;
	logic [GSZ_W-1:0] grid_w_q, grid_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			res_q <= RST_RESOLUTION;
			inv_q <= RST_INV_RES;
			check_r_q <= RST_CHECK_RAD;
			grid_w_q <= RST_GRID_SIZE;
			grid_h_q <= RST_GRID_SIZE;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_ORIGIN_X: origin_x_q <= cfg_wdata;
				CFG_ORIGIN_Y: origin_y_q <= cfg_wdata;
				CFG_RES:      res_q <= cfg_wdata[RAD_W-1:0];
				CFG_INV_RES:  inv_q <= cfg_wdata[RAD_W-1:0];
				CFG_CHECK_R:  check_r_q <= cfg_wdata[RAD_W-1:0];
				CFG_GRID_W:   grid_w_q <= cfg_wdata[GSZ_W-1:0];
				CFG_GRID_H:   grid_h_q <= cfg_wdata[GSZ_W-1:0];
				default:      ;
			endcase
		end
	end

	// Effective grid size, clamped to one and to the memory size.
	logic [LIM_W-1:0] w_eff, h_eff;

	always_comb begin
		priority if (grid_w_q == '0) w_eff = LIM_W'(1);
		else if (LIM_W'(grid_w_q) > LIM_W'(MAX_COLS)) w_eff = LIM_W'(MAX_COLS);
		else w_eff = LIM_W'(grid_w_q);
		priority if (grid_h_q == '0) h_eff = LIM_W'(1);
		else if (LIM_W'(grid_h_q) > LIM_W'(MAX_ROWS)) h_eff = LIM_W'(MAX_ROWS);
		else h_eff = LIM_W'(grid_h_q);
	end

	// Request fields.
	logic signed [POS_W-1:0]  in_pos_x, in_pos_y;
	logic [RAD_W-1:0]         in_disc_r;
	logic [IDX_W-1:0]         in_col, in_row;
	logic signed [CELL_W-1:0] in_value;

	assign in_pos_x  = in_data[23:0];
	assign in_pos_y  = in_data[47:24];
	assign in_disc_r = in_data[63:48];
	assign in_col    = in_data[71:64];
	assign in_row    = in_data[79:72];
	assign in_value  = in_data[87:80];

	req_t                     req_q;
	logic signed [POS_W:0]    rx_q, ry_q;
	logic [RAD_W-1:0]         rad_q;
	logic [IDX_W-1:0]         col_q, row_q;
	logic signed [CELL_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_t'(in_user);
			rx_q <= (POS_W+1)'(in_pos_x) - (POS_W+1)'(origin_x_q);
			ry_q <= (POS_W+1)'(in_pos_y) - (POS_W+1)'(origin_y_q);
			rad_q <= (req_t'(in_user) == REQ_QUERY) ? check_r_q : in_disc_r;
			col_q <= in_col;
			row_q <= in_row;
			value_q <= in_value;
		end
	end

	// Shared multiplier; its product is always registered before use.
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_q;
	logic signed [MUL_W-1:0]  rx_w, ry_w, rad_w, res_w, inv_w;
	logic signed [MUL_W-1:0]  dx_q, dy_q, dxb_q;
	logic [CW-1:0]            x_q, x_lo_q, x_hi_q;
	logic [RW-1:0]            y_q, y_lo_q, y_hi_q;

	assign rx_w  = MUL_W'(rx_q);
	assign ry_w  = MUL_W'(ry_q);
	assign rad_w = MUL_W'({1'b0, rad_q});
	assign res_w = MUL_W'({1'b0, res_q});
	assign inv_w = MUL_W'({1'b0, inv_q});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_sel)
			MS_X0: begin mul_a = rx_w - rad_w; mul_b = inv_w; end
			MS_X1: begin mul_a = rx_w + rad_w; mul_b = inv_w; end
			MS_Y0: begin mul_a = ry_w - rad_w; mul_b = inv_w; end
			MS_Y1: begin mul_a = ry_w + rad_w; mul_b = inv_w; end
			MS_RR: begin mul_a = rad_w; mul_b = rad_w; end
			MS_XB: begin mul_a = MUL_W'({1'b0, x_lo_q}); mul_b = res_w; end
			MS_YB: begin mul_a = MUL_W'({1'b0, y_lo_q}); mul_b = res_w; end
			MS_DY: begin mul_a = dy_q; mul_b = dy_q; end
			MS_DX: begin mul_a = dx_q; mul_b = dx_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// Product scaled by 2^-16, truncated toward zero.
	function automatic logic signed [EDGE_W-1:0] to_cell(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] q;
		q = p >>> 16;
		if (p[PROD_W-1] && (p[15:0] != '0)) q = q + PROD_W'(1);
		return q[EDGE_W-1:0];
	endfunction

	logic signed [EDGE_W-1:0] x0_q, x1_q, y0_q, y1_q;
	logic signed [PROD_W-1:0] rr_q, dy2_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_x0) x0_q <= to_cell(mul_q);
		if (cmd.cap_x1) x1_q <= to_cell(mul_q);
		if (cmd.cap_y0) y0_q <= to_cell(mul_q);
		if (cmd.cap_y1) y1_q <= to_cell(mul_q);
		if (cmd.cap_rr) rr_q <= mul_q;
		if (cmd.cap_dy2) dy2_q <= mul_q;
	end

	// Window clipping and the bounds test of a query.
	logic signed [EDGE_W-1:0] wm1, hm1, x_lo, x_hi, y_lo, y_hi;
	logic oob_q, empty_q;

	assign wm1  = EDGE_W'(w_eff) - EDGE_W'(1);
	assign hm1  = EDGE_W'(h_eff) - EDGE_W'(1);
	assign x_lo = (x0_q < 0) ? '0 : x0_q;
	assign x_hi = (x1_q > wm1) ? wm1 : x1_q;
	assign y_lo = (y0_q < 0) ? '0 : y0_q;
	assign y_hi = (y1_q > hm1) ? hm1 : y1_q;

	always_ff @(posedge clk) begin
		if (cmd.clip) begin
			x_lo_q <= x_lo[CW-1:0];
			x_hi_q <= x_hi[CW-1:0];
			y_lo_q <= y_lo[RW-1:0];
			y_hi_q <= y_hi[RW-1:0];
			empty_q <= (x_lo > x_hi) || (y_lo > y_hi);
			oob_q <= (x0_q < 0) || (x0_q > wm1) || (x1_q < 0) || (x1_q > wm1) ||
				(y0_q < 0) || (y0_q > hm1) || (y1_q < 0) || (y1_q > hm1);
		end
	end

	// Cell walk: corner offsets advance by one resolution per column or row.
	always_ff @(posedge clk) begin
		if (cmd.set_dxb) dxb_q <= mul_q[MUL_W-1:0] - rx_w;
		if (cmd.set_dy) begin
			dy_q <= mul_q[MUL_W-1:0] - ry_w;
			y_q <= y_lo_q;
		end else if (cmd.step_y) begin
			dy_q <= dy_q + res_w;
			y_q <= y_q + RW'(1);
		end
		if (cmd.row_start) begin
			dx_q <= dxb_q;
			x_q <= x_lo_q;
		end else if (cmd.step_x) begin
			dx_q <= dx_q + res_w;
			x_q <= x_q + CW'(1);
		end
	end

	// Grid memory with one write and one registered read port.
	logic signed [CELL_W-1:0] grid_mem [DEPTH];
	logic signed [CELL_W-1:0] rd_q;
	logic [AW-1:0] sweep_q;
	logic [CW-1:0] wr_col;
	logic [RW-1:0] wr_row;
	logic cell_ok;

	assign wr_col  = LIM_W'(col_q) < w_eff ? CW'(LIM_W'(col_q)) : '0;
	assign wr_row  = LIM_W'(row_q) < h_eff ? RW'(LIM_W'(row_q)) : '0;
	assign cell_ok = (LIM_W'(col_q) < w_eff) && (LIM_W'(row_q) < h_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_en) begin
			sweep_q <= sweep_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.sweep_en) grid_mem[sweep_q] <= CELL_UNK;
		else if (cmd.wr_cell && cell_ok) grid_mem[{wr_row, wr_col}] <= value_q;
		else if (cmd.wr_free) grid_mem[{y_q, x_q}] <= CELL_FREE;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) rd_q <= grid_mem[{y_q, x_q}];
	end

	// Pending result and the output register.
	status_t pend_status_q, out_status_q;
	logic    pend_safe_q, out_safe_q, out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			pend_status_q <= cmd.res_status;
			pend_safe_q <= cmd.res_safe;
		end
		if (cmd.out_load) begin
			out_status_q <= pend_status_q;
			out_safe_q <= pend_safe_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {5'b0, out_status_q, out_safe_q};

	assign sts.req_in     = req_t'(in_user);
	assign sts.req_q      = req_q;
	assign sts.sweep_last = &sweep_q;
	assign sts.oob        = oob_q;
	assign sts.empty      = empty_q;
	assign sts.in_circle  = (mul_q + dy2_q) <= rr_q;
	assign sts.cell_occ   = rd_q == CELL_OCC;
	assign sts.cell_unk   = rd_q == CELL_UNK;
	assign sts.x_end      = x_q == x_hi_q;
	assign sts.y_end      = y_q == y_hi_q;
	assign sts.out_busy   = out_valid_q && !out_ready;

endmodule

`default_nettype wire

@@ hdl/occupancy_grid_disc_safety_check_core.sv @@
// Top level of the occupancy grid disc safety check.
// Depends on ogdsc_pkg, ogdsc_ctrl and ogdsc_dp.
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tdata: pos_x,pos_y,disc_radius,cell_col,cell_row,
//                                     cell_value; tuser: req_type
// m_*       out  m_tvalid/m_tready    tdata: safe, status
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// After reset the grid memory is swept to unknown, one cell per cycle over all
// 2^(clog2(MAX_COLS)+clog2(MAX_ROWS)) cells (65536 by default); a clear request does the same.
// A disc mark or query first forms the window edges and the squared radius on the shared
// multiplier, then walks the window cells row by row through the single grid read port; an
// empty disc window or an out-of-bounds query ends the request without the walk.
// One request is in work at a time; a finished result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module occupancy_grid_disc_safety_check_core import ogdsc_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// Bits from 0: pos_x[24], pos_y[24], disc_radius[16], cell_col[8], cell_row[8],
	// cell_value[8].
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// Bits from 0: req_type[2].
	input  wire logic [1:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// Bits from 0: safe[1], status[2], zero fill[5].
	output logic [OUT_DATA_W-1:0]      m_tdata,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t   cmd;
	sts_t   sts;
	state_t state;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state == S_IDLE);

	ogdsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.sts      (sts),
		.cmd      (cmd),
		.state    (state)
	);

	ogdsc_dp #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_user   (s_tuser),
		.in_data   (s_tdata),
		.cfg_we    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("block took a second request right after one");

	a_safe_means_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[2:1] == ST_OK)
		else $error("safe result with a nonzero status");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while the block was idle");

endmodule

`default_nettype wire
